>>> sv/tdj_pkg.sv
package tdj_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int FRAC_BITS    = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int IDX_W        = 12;

    localparam int CW   = 32;            // coordinate and result width
    localparam int VW   = 6 * CW;        // one vertex word: rest xyz, deformed xyz
    localparam int EW   = CW + 1;        // edge difference
    localparam int PW   = 2 * EW;        // cofactor product
    localparam int AW   = PW + 1;        // adjugate entry
    localparam int LO_W = AW / 2;        // low part of a split adjugate entry
    localparam int HI_W = AW - LO_W;     // high part, signed
    localparam int PPW  = EW + HI_W;     // partial product width
    localparam int PRW  = EW + AW;       // full product width
    localparam int SUMW = PRW + 2;       // sum of three products
    localparam int NUMW = SUMW + FRAC_BITS;
    localparam int NW   = NUMW + 2;      // 2|n| + |d|
    localparam int DW   = SUMW + 1;      // 2|d|
    localparam int QW   = CW + 1;        // quotient bits kept
    localparam int RW   = DW + 1;        // partial remainder

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef logic signed [EW-1:0]   edge_t;
    typedef logic signed [AW-1:0]   adj_t;
    typedef logic signed [PPW-1:0]  part_t;
    typedef logic signed [PRW-1:0]  prod_t;
    typedef logic signed [SUMW-1:0] sum_t;

    typedef struct packed {
        logic [NW-1:0] n2;
        logic [DW-1:0] d2;
        logic          neg;
        logic          sing;
    } div_in_t;

endpackage

>>> sv/tdj_ram.sv
module tdj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/tdj_front.sv
module tdj_front import tdj_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [VW-1:0]     wdata,
    input  logic              rd_valid,
    input  logic [ADDR_W-1:0] raddr [4],
    output logic              valid,
    output edge_t             m [3][3],
    output edge_t             e [3][3]
);

    logic [VW-1:0] rdata [4];
    logic          rd_valid_reg;
    logic          valid_reg;
    edge_t         m_next [3][3];
    edge_t         e_next [3][3];
    edge_t         m_reg  [3][3];
    edge_t         e_reg  [3][3];

    // Four identical banks, one per corner, all written by every load.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        tdj_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (adv),
            .raddr (raddr[b]),
            .rdata (rdata[b])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m_next[k][c] = edge_t'(signed'(rdata[k+1][CW*c +: CW]))
                             - edge_t'(signed'(rdata[0][CW*c +: CW]));
                e_next[k][c] = edge_t'(signed'(rdata[k+1][CW*(c+3) +: CW]))
                             - edge_t'(signed'(rdata[0][CW*(c+3) +: CW]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else if (adv)
        begin
            rd_valid_reg <= rd_valid;
            valid_reg    <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg <= m_next;
            e_reg <= e_next;
        end
    end

    assign valid = valid_reg;
    assign m     = m_reg;
    assign e     = e_reg;

endmodule

>>> sv/tdj_adj.sv
module tdj_adj import tdj_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  edge_t m [3][3],
    input  edge_t e [3][3],
    output logic  valid,
    output adj_t  adj [3][3],
    output edge_t m0 [3],
    output edge_t e_out [3][3]
);

    logic signed [PW-1:0] pa_next [9];
    logic signed [PW-1:0] pb_next [9];
    logic signed [PW-1:0] pa_reg  [9];
    logic signed [PW-1:0] pb_reg  [9];
    edge_t                m0_s1_reg [3];
    edge_t                e_s1_reg  [3][3];
    edge_t                m0_reg    [3];
    edge_t                e_reg     [3][3];
    adj_t                 adj_reg   [3][3];
    logic                 v1_reg;
    logic                 v2_reg;

    function automatic logic signed [PW-1:0] mul_e(edge_t a, edge_t b);
        return PW'(a) * PW'(b);
    endfunction

    // Cofactor products, entry r*3+c of the adjugate is pa - pb.
    always_comb
    begin
        pa_next[0] = mul_e(m[1][1], m[2][2]);  pb_next[0] = mul_e(m[1][2], m[2][1]);
        pa_next[1] = mul_e(m[0][2], m[2][1]);  pb_next[1] = mul_e(m[0][1], m[2][2]);
        pa_next[2] = mul_e(m[0][1], m[1][2]);  pb_next[2] = mul_e(m[0][2], m[1][1]);
        pa_next[3] = mul_e(m[1][2], m[2][0]);  pb_next[3] = mul_e(m[1][0], m[2][2]);
        pa_next[4] = mul_e(m[0][0], m[2][2]);  pb_next[4] = mul_e(m[0][2], m[2][0]);
        pa_next[5] = mul_e(m[0][2], m[1][0]);  pb_next[5] = mul_e(m[0][0], m[1][2]);
        pa_next[6] = mul_e(m[1][0], m[2][1]);  pb_next[6] = mul_e(m[1][1], m[2][0]);
        pa_next[7] = mul_e(m[0][1], m[2][0]);  pb_next[7] = mul_e(m[0][0], m[2][1]);
        pa_next[8] = mul_e(m[0][0], m[1][1]);  pb_next[8] = mul_e(m[0][1], m[1][0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            m0_s1_reg <= m[0];
            e_s1_reg  <= e;
            m0_reg    <= m0_s1_reg;
            e_reg     <= e_s1_reg;
            for (int i = 0; i < 9; i++)
            begin
                adj_reg[i/3][i%3] <= AW'(pa_reg[i]) - AW'(pb_reg[i]);
            end
        end
    end

    assign valid = v2_reg;
    assign adj   = adj_reg;
    assign m0    = m0_reg;
    assign e_out = e_reg;

endmodule

>>> sv/tdj_prod.sv
module tdj_prod import tdj_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    in_valid,
    input  adj_t    adj [3][3],
    input  edge_t   m0  [3],
    input  edge_t   e   [3][3],
    output logic    valid,
    output div_in_t dv  [3][3]
);

    part_t             dlo_reg [3];
    part_t             dhi_reg [3];
    part_t             nlo_reg [3][3][3];
    part_t             nhi_reg [3][3][3];
    prod_t             dfull_reg [3];
    prod_t             nfull_reg [3][3][3];
    sum_t              det_reg;
    sum_t              num_reg [3][3];
    logic [NUMW-1:0]   nabs_reg [3][3];
    logic              nneg_reg [3][3];
    logic [SUMW-1:0]   dabs_reg;
    logic              dneg_reg;
    logic              sing_reg;
    div_in_t           dv_reg [3][3];
    logic [4:0]        v_reg;

    // Adjugate entries are split so that every multiplier stays near 33 bits.
    function automatic part_t mul_lo(edge_t a, adj_t b);
        return PPW'(a) * PPW'(signed'({1'b0, b[LO_W-1:0]}));
    endfunction

    function automatic part_t mul_hi(edge_t a, adj_t b);
        return PPW'(a) * PPW'(signed'(b[AW-1:LO_W]));
    endfunction

    function automatic prod_t join_parts(part_t hi, part_t lo);
        return (PRW'(hi) <<< LO_W) + PRW'(lo);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dlo_reg[k]   <= mul_lo(m0[k], adj[k][0]);
                dhi_reg[k]   <= mul_hi(m0[k], adj[k][0]);
                dfull_reg[k] <= join_parts(dhi_reg[k], dlo_reg[k]);
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        nlo_reg[i][c][k]   <= mul_lo(e[k][c], adj[i][k]);
                        nhi_reg[i][c][k]   <= mul_hi(e[k][c], adj[i][k]);
                        nfull_reg[i][c][k] <= join_parts(nhi_reg[i][c][k],
                                                         nlo_reg[i][c][k]);
                    end
                    num_reg[i][c] <= SUMW'(nfull_reg[i][c][0]) + SUMW'(nfull_reg[i][c][1])
                                   + SUMW'(nfull_reg[i][c][2]);
                end
            end
            det_reg <= SUMW'(dfull_reg[0]) + SUMW'(dfull_reg[1]) + SUMW'(dfull_reg[2]);

            // Magnitudes and signs; the numerator picks up the fraction scale here.
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    nneg_reg[i][c] <= num_reg[i][c][SUMW-1];
                    nabs_reg[i][c] <= num_reg[i][c][SUMW-1]
                                    ? NUMW'(-(NUMW'(num_reg[i][c]) <<< FRAC_BITS))
                                    : NUMW'(NUMW'(num_reg[i][c]) <<< FRAC_BITS);
                end
            end
            dneg_reg <= det_reg[SUMW-1];
            dabs_reg <= det_reg[SUMW-1] ? SUMW'(-det_reg) : SUMW'(det_reg);
            sing_reg <= (det_reg == '0);

            // Rounding to nearest, ties away from zero: floor((2n + d) / 2d).
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    dv_reg[i][c].n2   <= (NW'(nabs_reg[i][c]) << 1) + NW'(dabs_reg);
                    dv_reg[i][c].d2   <= DW'(dabs_reg) << 1;
                    dv_reg[i][c].neg  <= nneg_reg[i][c] ^ dneg_reg;
                    dv_reg[i][c].sing <= sing_reg;
                end
            end
        end
    end

    assign valid = v_reg[4];
    assign dv    = dv_reg;

endmodule

>>> sv/tdj_div.sv
module tdj_div import tdj_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  div_in_t       din,
    output logic          valid,
    output logic [CW-1:0] j,
    output logic          sat,
    output logic          sing
);

    logic [RW-1:0] r_reg    [QW+1];
    logic [QW-1:0] low_reg  [QW+1];
    logic [QW-1:0] q_reg    [QW+1];
    logic [DW-1:0] d2_reg   [QW+1];
    logic          ovf_reg  [QW+1];
    logic          neg_reg  [QW+1];
    logic          sing_reg [QW+1];
    logic          vld_reg  [QW+1];
    logic          valid_reg;
    logic [CW-1:0] j_reg;
    logic          sat_reg;
    logic          sing_out_reg;
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    logic [QW-1:0] sval;
    logic          clip;

    // The quotient needs only QW bits: a top part at or above the divisor
    // means the result is out of range anyway.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0]    <= RW'(din.n2[NW-1:QW]);
            ovf_reg[0]  <= RW'(din.n2[NW-1:QW]) >= RW'(din.d2);
            low_reg[0]  <= din.n2[QW-1:0];
            q_reg[0]    <= '0;
            d2_reg[0]   <= din.d2;
            neg_reg[0]  <= din.neg;
            sing_reg[0] <= din.sing;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = {r_reg[s][RW-2:0], low_reg[s][QW-1]};
        assign ge    = trial >= RW'(d2_reg[s]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[s+1]    <= ge ? trial - RW'(d2_reg[s]) : trial;
                low_reg[s+1]  <= {low_reg[s][QW-2:0], 1'b0};
                q_reg[s+1]    <= {q_reg[s][QW-2:0], ge};
                d2_reg[s+1]   <= d2_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                sing_reg[s+1] <= sing_reg[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
    end

    always_comb
    begin
        lim  = neg_reg[QW] ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
        clip = ovf_reg[QW] || (q_reg[QW] > lim);
        mag  = clip ? lim : q_reg[QW];
        sval = neg_reg[QW] ? -mag : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_reg        <= sing_reg[QW] ? '0 : sval[CW-1:0];
            sat_reg      <= !sing_reg[QW] && clip;
            sing_out_reg <= sing_reg[QW];
        end
    end

    assign valid = valid_reg;
    assign j     = j_reg;
    assign sat   = sat_reg;
    assign sing  = sing_out_reg;

endmodule

>>> sv/tet_deformation_jacobian.sv
// Tetrahedron deformation gradient, J = inverse(R) * D in signed Q16.16, where
// the rows of R and D are the rest and deformed edges from corner a to corners
// b, c and d. A load word (opcode 0) writes one vertex and gives no result; a
// compute word (opcode 1) gives one result, and a new word is taken every
// cycle while the output is not stalled. The pipeline is the vertex read (on
// four replicated store banks), one edge stage, two adjugate stages, five
// product and rounding stages and a 35 stage restoring divider (an entry
// stage, one stage per quotient bit for 33 bits and an output stage), nine
// lanes wide. When the output word is not taken the whole pipeline holds.
// A compute word sees every load accepted before it.
module tet_deformation_jacobian import tdj_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [IDX_W-1:0]     vertex_index,
    input  logic signed [CW-1:0] rest_px,
    input  logic signed [CW-1:0] rest_py,
    input  logic signed [CW-1:0] rest_pz,
    input  logic signed [CW-1:0] def_px,
    input  logic signed [CW-1:0] def_py,
    input  logic signed [CW-1:0] def_pz,
    input  logic [IDX_W-1:0]     corner_a,
    input  logic [IDX_W-1:0]     corner_b,
    input  logic [IDX_W-1:0]     corner_c,
    input  logic [IDX_W-1:0]     corner_d,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] j_r0c0,
    output logic signed [CW-1:0] j_r0c1,
    output logic signed [CW-1:0] j_r0c2,
    output logic signed [CW-1:0] j_r1c0,
    output logic signed [CW-1:0] j_r1c1,
    output logic signed [CW-1:0] j_r1c2,
    output logic signed [CW-1:0] j_r2c0,
    output logic signed [CW-1:0] j_r2c1,
    output logic signed [CW-1:0] j_r2c2,
    output logic                 singular,
    output logic                 saturated
);

    logic              adv;
    logic              acc;
    logic [ADDR_W-1:0] raddr [4];
    logic              f_valid;
    edge_t             f_m [3][3];
    edge_t             f_e [3][3];
    logic              a_valid;
    adj_t              a_adj [3][3];
    edge_t             a_m0 [3];
    edge_t             a_e [3][3];
    logic              p_valid;
    div_in_t           p_dv [3][3];
    logic [8:0]        lane_valid;
    logic [CW-1:0]     lane_j [9];
    logic [8:0]        lane_sat;
    logic [8:0]        lane_sing;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign acc      = in_valid && in_ready;

    assign raddr[0] = corner_a[ADDR_W-1:0];
    assign raddr[1] = corner_b[ADDR_W-1:0];
    assign raddr[2] = corner_c[ADDR_W-1:0];
    assign raddr[3] = corner_d[ADDR_W-1:0];

    tdj_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .we       (acc && opcode == OP_LOAD),
        .waddr    (vertex_index[ADDR_W-1:0]),
        .wdata    ({def_pz, def_py, def_px, rest_pz, rest_py, rest_px}),
        .rd_valid (acc && opcode == OP_COMPUTE),
        .raddr    (raddr),
        .valid    (f_valid),
        .m        (f_m),
        .e        (f_e)
    );

    tdj_adj u_adj (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (f_valid),
        .m        (f_m),
        .e        (f_e),
        .valid    (a_valid),
        .adj      (a_adj),
        .m0       (a_m0),
        .e_out    (a_e)
    );

    tdj_prod u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (a_valid),
        .adj      (a_adj),
        .m0       (a_m0),
        .e        (a_e),
        .valid    (p_valid),
        .dv       (p_dv)
    );

    for (genvar i = 0; i < 9; i++)
    begin : g_lane
        tdj_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_valid (p_valid),
            .din      (p_dv[i/3][i%3]),
            .valid    (lane_valid[i]),
            .j        (lane_j[i]),
            .sat      (lane_sat[i]),
            .sing     (lane_sing[i])
        );
    end

    // All nine lanes move in lockstep, so their valid and singular bits agree.
    assign out_valid = &lane_valid;
    assign j_r0c0    = signed'(lane_j[0]);
    assign j_r0c1    = signed'(lane_j[1]);
    assign j_r0c2    = signed'(lane_j[2]);
    assign j_r1c0    = signed'(lane_j[3]);
    assign j_r1c1    = signed'(lane_j[4]);
    assign j_r1c2    = signed'(lane_j[5]);
    assign j_r2c0    = signed'(lane_j[6]);
    assign j_r2c1    = signed'(lane_j[7]);
    assign j_r2c2    = signed'(lane_j[8]);
    assign singular  = &lane_sing;
    assign saturated = |lane_sat;

endmodule

>>> sv/tdj_checker.sv
module tdj_checker import tdj_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 opcode,
    input logic [IDX_W-1:0]     vertex_index,
    input logic signed [CW-1:0] rest_px,
    input logic signed [CW-1:0] rest_py,
    input logic signed [CW-1:0] rest_pz,
    input logic signed [CW-1:0] def_px,
    input logic signed [CW-1:0] def_py,
    input logic signed [CW-1:0] def_pz,
    input logic [IDX_W-1:0]     corner_a,
    input logic [IDX_W-1:0]     corner_b,
    input logic [IDX_W-1:0]     corner_c,
    input logic [IDX_W-1:0]     corner_d,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [CW-1:0] j_r0c0,
    input logic signed [CW-1:0] j_r0c1,
    input logic signed [CW-1:0] j_r0c2,
    input logic signed [CW-1:0] j_r1c0,
    input logic signed [CW-1:0] j_r1c1,
    input logic signed [CW-1:0] j_r1c2,
    input logic signed [CW-1:0] j_r2c0,
    input logic signed [CW-1:0] j_r2c1,
    input logic signed [CW-1:0] j_r2c2,
    input logic                 singular,
    input logic                 saturated
);

    localparam logic signed [CW-1:0] JMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] JMIN = {1'b1, {(CW-1){1'b0}}};

    // A held output word keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(j_r0c0) && $stable(j_r1c1)
            && $stable(j_r2c2) && $stable(singular) && $stable(saturated))
        else $error("output word changed while stalled");

    // Input is taken exactly when the pipeline can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output backpressure");

    // A singular rest matrix gives an all-zero, unclipped result.
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !saturated && j_r0c0 == 0 && j_r0c1 == 0
            && j_r0c2 == 0 && j_r1c0 == 0 && j_r1c1 == 0 && j_r1c2 == 0
            && j_r2c0 == 0 && j_r2c1 == 0 && j_r2c2 == 0)
        else $error("singular result is not zero");

    // Clipping leaves at least one entry at a rail.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            j_r0c0 == JMAX || j_r0c0 == JMIN || j_r0c1 == JMAX || j_r0c1 == JMIN
            || j_r0c2 == JMAX || j_r0c2 == JMIN || j_r1c0 == JMAX || j_r1c0 == JMIN
            || j_r1c1 == JMAX || j_r1c1 == JMIN || j_r1c2 == JMAX || j_r1c2 == JMIN
            || j_r2c0 == JMAX || j_r2c0 == JMIN || j_r2c1 == JMAX || j_r2c1 == JMIN
            || j_r2c2 == JMAX || j_r2c2 == JMIN)
        else $error("saturated flag without a clipped entry");

endmodule

bind tet_deformation_jacobian tdj_checker u_checker (.*);
